### sv/tdpg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trial-division prime generator package
// Widths, limits and fixed values shared by the generator.
// ----------------------------------------------------------------------------
package tdpg_pkg;

    localparam int CAND_W  = 16;   // candidate and prime value width
    localparam int ORD_W   = 12;   // ordinal width
    localparam int COUNT_W = 13;   // configured count and produced count width
    localparam int DIV_W   = 11;   // stored divisor width, covers a table of up to 256 primes

    localparam int DIVISOR_DEPTH_DEF = 64;

    localparam logic [COUNT_W-1:0] MAX_PRIMES        = COUNT_W'(4096);
    localparam logic [COUNT_W-1:0] PRIME_COUNT_RESET = COUNT_W'(4096);

    localparam logic [CAND_W-1:0] FIRST_PRIME = CAND_W'(2);
    localparam logic [CAND_W-1:0] FIRST_ODD   = CAND_W'(3);

    // remainder bits resolved per divider cycle
    localparam int STEP_BITS = 4;

endpackage

### sv/trial_division_prime_generator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trial-division prime generator
// Gives the primes in ascending order, one per request, starting with 2.
// ----------------------------------------------------------------------------
// Each request without restart returns the next prime, its zero-based ordinal
// and a flag on the final prime of the run; once prime_count primes (at most
// MAX_PRIMES) are out, or no prime remains below 65536, a request returns the
// exhausted flag. A restart request clears the run and returns all zeros.
// Restart, exhausted and the first prime go from idle straight to the result
// state. Any other request tests candidates from the one above the last prime
// upwards against the divisor table, one divisor at a time: a memory read
// issued ahead, a square compare and a remainder unit (4 bits a cycle) that
// resolves the candidate in steps of STEP_BITS.
// Requests are taken one at a time; a new request is taken while the previous
// result still waits at the output.
// ----------------------------------------------------------------------------
module trial_division_prime_generator_top
    import tdpg_pkg::*;
#(
    parameter int DIVISOR_DEPTH = DIVISOR_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [COUNT_W-1:0] prime_count,

    input  logic               in_valid,
    output logic               in_stall,
    input  logic               restart,

    output logic               out_valid,
    input  logic               out_stall,
    output logic [CAND_W-1:0]  prime_value,
    output logic [ORD_W-1:0]   prime_ordinal,
    output logic               last_prime,
    output logic               exhausted
);

    localparam int IDX_W    = (DIVISOR_DEPTH > 1) ? $clog2(DIVISOR_DEPTH) : 1;
    localparam int FILL_W   = $clog2(DIVISOR_DEPTH + 1);
    localparam int STEPS    = CAND_W / STEP_BITS;
    localparam int STEP_CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    localparam logic [FILL_W-1:0]     DEPTH_FILL = FILL_W'(DIVISOR_DEPTH);
    localparam logic [STEP_CNT_W-1:0] STEP_LAST  = STEP_CNT_W'(STEPS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CAND,
        ST_TEST,
        ST_DIV,
        ST_FOUND,
        ST_RESULT
    } state_t;

    // divisor table
    logic [DIV_W-1:0] table_mem [DIVISOR_DEPTH];
    logic [DIV_W-1:0] rd_data_reg;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [DIV_W-1:0] wr_data;

    state_t                state_reg, state_next;
    logic [COUNT_W-1:0]    prime_count_reg;
    logic [FILL_W-1:0]     fill_reg, fill_next;
    logic [CAND_W-1:0]     next_cand_reg, next_cand_next;
    logic [COUNT_W-1:0]    produced_reg, produced_next;
    logic [CAND_W:0]       cand_reg, cand_next;
    logic [FILL_W-1:0]     idx_reg, idx_next;
    logic [DIV_W-1:0]      rem_reg, rem_next;
    logic [CAND_W-1:0]     dvd_reg, dvd_next;
    logic [STEP_CNT_W-1:0] step_reg, step_next;

    logic [CAND_W-1:0]     res_value_reg, res_value_next;
    logic [ORD_W-1:0]      res_ordinal_reg, res_ordinal_next;
    logic                  res_last_reg, res_last_next;
    logic                  res_exh_reg, res_exh_next;

    logic                  out_valid_reg;
    logic [CAND_W-1:0]     prime_value_reg;
    logic [ORD_W-1:0]      prime_ordinal_reg;
    logic                  last_prime_reg;
    logic                  exhausted_reg;

    logic [COUNT_W-1:0]    limit;
    logic [COUNT_W-1:0]    produced_inc;
    logic [2*DIV_W-1:0]    square;
    logic [DIV_W-1:0]      div_rem;
    logic [CAND_W-1:0]     div_dvd;
    logic [FILL_W-1:0]     idx_inc;
    logic                  in_accept;
    logic                  out_load;

    assign limit        = (prime_count_reg > MAX_PRIMES) ? MAX_PRIMES : prime_count_reg;
    assign produced_inc = produced_reg + COUNT_W'(1);
    assign square       = (2*DIV_W)'(rd_data_reg) * (2*DIV_W)'(rd_data_reg);
    assign idx_inc      = idx_reg + FILL_W'(1);
    assign in_accept    = in_valid && !in_stall;
    assign out_load     = (state_reg == ST_RESULT) && (!out_valid_reg || !out_stall);

    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;

    assign out_valid     = out_valid_reg;
    assign prime_value   = prime_value_reg;
    assign prime_ordinal = prime_ordinal_reg;
    assign last_prime    = last_prime_reg;
    assign exhausted     = exhausted_reg;

    // remainder unit: STEP_BITS restoring steps a cycle
    always_comb
    begin
        logic [DIV_W:0]    t;
        logic [DIV_W-1:0]  r;
        logic [CAND_W-1:0] d;
        r = rem_reg;
        d = dvd_reg;
        for (int k = 0; k < STEP_BITS; k++)
        begin
            t = {r, d[CAND_W-1]};
            d = {d[CAND_W-2:0], 1'b0};
            if (t >= {1'b0, rd_data_reg})
            begin
                t = t - {1'b0, rd_data_reg};
            end
            r = t[DIV_W-1:0];
        end
        div_rem = r;
        div_dvd = d;
    end

    always_comb
    begin
        state_next       = state_reg;
        fill_next        = fill_reg;
        next_cand_next   = next_cand_reg;
        produced_next    = produced_reg;
        cand_next        = cand_reg;
        idx_next         = idx_reg;
        rem_next         = rem_reg;
        dvd_next         = dvd_reg;
        step_next        = step_reg;
        res_value_next   = res_value_reg;
        res_ordinal_next = res_ordinal_reg;
        res_last_next    = res_last_reg;
        res_exh_next     = res_exh_reg;
        rd_en            = 1'b0;
        rd_addr          = '0;
        wr_en            = 1'b0;
        wr_addr          = fill_reg[IDX_W-1:0];
        wr_data          = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    res_value_next   = '0;
                    res_ordinal_next = '0;
                    res_last_next    = 1'b0;
                    res_exh_next     = 1'b0;
                    if (restart)
                    begin
                        fill_next      = '0;
                        next_cand_next = FIRST_ODD;
                        produced_next  = '0;
                        state_next     = ST_RESULT;
                    end
                    else if (produced_reg >= limit)
                    begin
                        res_exh_next = 1'b1;
                        state_next   = ST_RESULT;
                    end
                    else if (produced_reg == '0)
                    begin
                        if (fill_reg < DEPTH_FILL)
                        begin
                            wr_en     = 1'b1;
                            wr_data   = DIV_W'(FIRST_PRIME);
                            fill_next = fill_reg + FILL_W'(1);
                        end
                        res_value_next   = FIRST_PRIME;
                        res_ordinal_next = produced_reg[ORD_W-1:0];
                        res_last_next    = (produced_inc == limit);
                        produced_next    = produced_inc;
                        state_next       = ST_RESULT;
                    end
                    else
                    begin
                        cand_next  = {1'b0, next_cand_reg};
                        state_next = ST_CAND;
                    end
                end
            end

            ST_CAND:
            begin
                if (cand_reg[CAND_W])
                begin
                    res_exh_next = 1'b1;
                    state_next   = ST_RESULT;
                end
                else if (fill_reg == '0)
                begin
                    state_next = ST_FOUND;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = '0;
                    idx_next   = '0;
                    state_next = ST_TEST;
                end
            end

            ST_TEST:
            begin
                if ((rd_data_reg < DIV_W'(2)) ||
                    (square > (2*DIV_W)'(cand_reg[CAND_W-1:0])))
                begin
                    state_next = ST_FOUND;
                end
                else
                begin
                    rem_next   = '0;
                    dvd_next   = cand_reg[CAND_W-1:0];
                    step_next  = '0;
                    state_next = ST_DIV;
                end
            end

            ST_DIV:
            begin
                rem_next  = div_rem;
                dvd_next  = div_dvd;
                step_next = step_reg + STEP_CNT_W'(1);
                if (step_reg == STEP_LAST)
                begin
                    if (div_rem == '0)
                    begin
                        cand_next  = cand_reg + (CAND_W+1)'(1);
                        state_next = ST_CAND;
                    end
                    else if (idx_inc == fill_reg)
                    begin
                        state_next = ST_FOUND;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = idx_inc[IDX_W-1:0];
                        idx_next   = idx_inc;
                        state_next = ST_TEST;
                    end
                end
            end

            ST_FOUND:
            begin
                if (fill_reg < DEPTH_FILL)
                begin
                    wr_en     = 1'b1;
                    wr_data   = DIV_W'(cand_reg[CAND_W-1:0]);
                    fill_next = fill_reg + FILL_W'(1);
                end
                next_cand_next   = cand_reg[CAND_W-1:0] + CAND_W'(1);
                res_value_next   = cand_reg[CAND_W-1:0];
                res_ordinal_next = produced_reg[ORD_W-1:0];
                res_last_next    = (produced_inc == limit);
                res_exh_next     = 1'b0;
                produced_next    = produced_inc;
                state_next       = ST_RESULT;
            end

            ST_RESULT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= table_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            prime_count_reg <= PRIME_COUNT_RESET;
            fill_reg        <= '0;
            next_cand_reg   <= FIRST_ODD;
            produced_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            next_cand_reg <= next_cand_next;
            produced_reg  <= produced_next;
            if (cfg_valid && cfg_ready)
            begin
                prime_count_reg <= prime_count;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cand_reg        <= cand_next;
        idx_reg         <= idx_next;
        rem_reg         <= rem_next;
        dvd_reg         <= dvd_next;
        step_reg        <= step_next;
        res_value_reg   <= res_value_next;
        res_ordinal_reg <= res_ordinal_next;
        res_last_reg    <= res_last_next;
        res_exh_reg     <= res_exh_next;
        if (out_load)
        begin
            prime_value_reg   <= res_value_reg;
            prime_ordinal_reg <= res_ordinal_reg;
            last_prime_reg    <= res_last_reg;
            exhausted_reg     <= res_exh_reg;
        end
    end

endmodule
